### hw/rtl/text_console_writer_top_defines.svh
// ----------------------------------------------------------------------------
// text_console_writer_top_defines.svh
// Assertion macros for the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Field widths, request codes and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int MODE_W = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + ATTR_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT    = 3'd0,
    MODE_SHOW   = 3'd1,
    MODE_SETCUR = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

  typedef struct packed {
    logic in_ready;
    logic latch_item;
    logic calc_addr;
    logic write_cell;
    logic read_cell;
    logic capture_read;
    logic cur_advance;
    logic cur_newline;
    logic cur_set;
    logic cur_home;
    logic scroll_start;
    logic clear_start;
    logic sweep_step;
    logic set_dropped;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              is_newline;
    logic              is_nul;
    logic              in_range;
    logic              at_last_col;
    logic              at_bottom;
    logic              sweep_last;
    logic              out_free;
  } tcw_stat_t;

endpackage

### hw/rtl/tcw_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_item_if
// Request channel: valid/ready plus one request beat.
// ----------------------------------------------------------------------------
interface tcw_item_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::MODE_W-1:0] mode;
  logic [tcw_pkg::CHAR_W-1:0] character;
  logic [tcw_pkg::ATTR_W-1:0] attrib;
  logic [tcw_pkg::COL_W-1:0]  col;
  logic [tcw_pkg::ROW_W-1:0]  row;

  modport source (output valid, mode, character, attrib, col, row, input ready);
  modport sink   (input valid, mode, character, attrib, col, row, output ready);
endinterface

### hw/rtl/tcw_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_result_if
// Result channel: valid/ready plus one result beat.
// ----------------------------------------------------------------------------
interface tcw_result_if;
  logic                       valid;
  logic                       ready;
  logic [tcw_pkg::COL_W-1:0]  cursor_col;
  logic [tcw_pkg::ROW_W-1:0]  cursor_row;
  logic [tcw_pkg::CHAR_W-1:0] cell_char;
  logic [tcw_pkg::ATTR_W-1:0] cell_attr;
  logic                       scrolled;
  logic                       dropped;

  modport source (output valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  dropped, input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_char, cell_attr, scrolled,
                  dropped, output ready);
endinterface

### hw/rtl/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Request latch, cursor, row rotation, cell store, sweep counter and
// result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
  parameter int SCREEN_COLS   = 80,
  parameter int SCREEN_ROWS_N = 25
) (
  input  logic                clk,
  input  logic                rst,
  tcw_item_if.sink            item,
  tcw_result_if.source        result,
  input  tcw_pkg::tcw_cmd_t   cmd,
  output tcw_pkg::tcw_stat_t  stat
);

  localparam int MODE_W     = tcw_pkg::MODE_W;
  localparam int CHAR_W     = tcw_pkg::CHAR_W;
  localparam int ATTR_W     = tcw_pkg::ATTR_W;
  localparam int COL_W      = tcw_pkg::COL_W;
  localparam int ROW_W      = tcw_pkg::ROW_W;
  localparam int CELL_W     = tcw_pkg::CELL_W;
  localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS_N;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam logic [COL_W-1:0]  NUM_COLS  = COL_W'(SCREEN_COLS);
  localparam logic [ROW_W-1:0]  NUM_ROWS  = ROW_W'(SCREEN_ROWS_N);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS_N - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  // latched request
  logic [MODE_W-1:0] it_mode;
  logic [CHAR_W-1:0] it_char;
  logic [ATTR_W-1:0] it_attr;
  logic [COL_W-1:0]  it_col;
  logic [ROW_W-1:0]  it_row;

  // cursor and top-row pointer into the rotating store
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ROW_W-1:0]  base;

  logic [ROW_W-1:0]  phys_row;
  logic              in_range;

  logic [ADDR_W-1:0] sweep_addr;
  logic [ADDR_W-1:0] sweep_end;

  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_scrolled;
  logic              res_dropped;

  logic              out_valid;
  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [CHAR_W-1:0] out_char;
  logic [ATTR_W-1:0] out_attr;
  logic              out_scrolled;
  logic              out_dropped;

  logic [ROW_W-1:0]  tgt_row;
  logic [COL_W-1:0]  tgt_col;
  logic [ROW_W:0]    row_sum;
  logic [ROW_W-1:0]  phys_row_next;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] row_base;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;

  assign tgt_row = (it_mode == tcw_pkg::MODE_PUT) ? cur_row : it_row;
  assign tgt_col = (it_mode == tcw_pkg::MODE_PUT) ? cur_col : it_col;

  // logical row -> physical row, base < rows so one subtract is enough
  assign row_sum = {1'b0, base} + {1'b0, tgt_row};
  assign phys_row_next = (row_sum >= {1'b0, NUM_ROWS}) ? ROW_W'(row_sum - {1'b0, NUM_ROWS})
                                                       : row_sum[ROW_W-1:0];

  assign cell_addr = ADDR_W'(phys_row) * ROW_SPAN + ADDR_W'(tgt_col);
  assign row_base  = ADDR_W'(base) * ROW_SPAN;

  assign ram_we    = cmd.write_cell | cmd.sweep_step;
  assign ram_waddr = cmd.sweep_step ? sweep_addr : cell_addr;
  assign ram_wdata = cmd.sweep_step ? '0 : {it_attr, it_char};

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.read_cell),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      it_mode <= item.mode;
      it_char <= item.character;
      it_attr <= item.attrib;
      it_col  <= item.col;
      it_row  <= item.row;
    end
    if (cmd.calc_addr) begin
      phys_row <= phys_row_next;
      in_range <= (it_col < NUM_COLS) && (it_row < NUM_ROWS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      base    <= '0;
    end else begin
      if (cmd.cur_home) begin
        cur_col <= '0;
        cur_row <= '0;
      end else if (cmd.cur_set) begin
        cur_col <= it_col;
        cur_row <= it_row;
      end else if (cmd.cur_newline) begin
        cur_col <= '0;
        if (cur_row != LAST_ROW) begin
          cur_row <= cur_row + 1'b1;
        end
      end else if (cmd.cur_advance) begin
        cur_col <= cur_col + 1'b1;
      end
      if (cmd.scroll_start) begin
        base <= (base == LAST_ROW) ? '0 : base + 1'b1;
      end
    end
  end

  // sweep starts over the full store out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_end  <= LAST_ADDR;
    end else if (cmd.scroll_start) begin
      sweep_addr <= row_base;
      sweep_end  <= row_base + ADDR_W'(SCREEN_COLS - 1);
    end else if (cmd.clear_start) begin
      sweep_addr <= '0;
      sweep_end  <= LAST_ADDR;
    end else if (cmd.sweep_step) begin
      sweep_addr <= sweep_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      res_char     <= '0;
      res_attr     <= '0;
      res_scrolled <= 1'b0;
      res_dropped  <= 1'b0;
    end else begin
      if (cmd.capture_read) begin
        res_char <= ram_rdata[CHAR_W-1:0];
        res_attr <= ram_rdata[CELL_W-1:CHAR_W];
      end
      if (cmd.scroll_start) begin
        res_scrolled <= 1'b1;
      end
      if (cmd.set_dropped) begin
        res_dropped <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col      <= cur_col;
      out_row      <= cur_row;
      out_char     <= res_char;
      out_attr     <= res_attr;
      out_scrolled <= res_scrolled;
      out_dropped  <= res_dropped;
    end
  end

  assign item.ready        = cmd.in_ready;
  assign result.valid      = out_valid;
  assign result.cursor_col = out_col;
  assign result.cursor_row = out_row;
  assign result.cell_char  = out_char;
  assign result.cell_attr  = out_attr;
  assign result.scrolled   = out_scrolled;
  assign result.dropped    = out_dropped;

  assign stat.mode        = it_mode;
  assign stat.is_newline  = (it_char == tcw_pkg::CHAR_NEWLINE);
  assign stat.is_nul      = (it_char == tcw_pkg::CHAR_NUL);
  assign stat.in_range    = in_range;
  assign stat.at_last_col = (cur_col == LAST_COL);
  assign stat.at_bottom   = (cur_row == LAST_ROW);
  assign stat.sweep_last  = (sweep_addr == sweep_end);
  assign stat.out_free    = !out_valid || result.ready;

endmodule

### hw/rtl/tcw_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_controller
// Request sequencer: decodes the latched request and steps the datapath.
// ----------------------------------------------------------------------------
module tcw_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  tcw_pkg::tcw_stat_t stat,
  output tcw_pkg::tcw_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_ADDR  = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_READ  = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (item_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_next    = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (stat.mode)
          tcw_pkg::MODE_PUT: begin
            if (stat.is_newline) begin
              cmd.cur_newline = 1'b1;
              if (stat.at_bottom) begin
                cmd.scroll_start = 1'b1;
                state_next       = S_SWEEP;
              end
            end else if (!stat.is_nul) begin
              cmd.write_cell = 1'b1;
              if (stat.at_last_col) begin
                cmd.cur_newline = 1'b1;
                if (stat.at_bottom) begin
                  cmd.scroll_start = 1'b1;
                  state_next       = S_SWEEP;
                end
              end else begin
                cmd.cur_advance = 1'b1;
              end
            end
          end
          tcw_pkg::MODE_SHOW: begin
            cmd.write_cell  = stat.in_range;
            cmd.set_dropped = !stat.in_range;
          end
          tcw_pkg::MODE_SETCUR: begin
            cmd.cur_set     = stat.in_range;
            cmd.set_dropped = !stat.in_range;
          end
          tcw_pkg::MODE_CLEAR: begin
            cmd.clear_start = 1'b1;
            cmd.cur_home    = 1'b1;
            state_next      = S_SWEEP;
          end
          tcw_pkg::MODE_READ: begin
            if (stat.in_range) begin
              cmd.read_cell = 1'b1;
              state_next    = S_READ;
            end else begin
              cmd.set_dropped = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        cmd.capture_read = 1'b1;
        state_next       = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

### hw/rtl/text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console engine: cell store, cursor and request handling.
// ----------------------------------------------------------------------------
// One request is in flight at a time and every request returns one result
// beat. After reset the block zeroes its whole cell store before taking
// the first request. A request then passes through accept, address,
// execute and result load; a read adds a step for the registered RAM
// read. Screen rows live in the store as a ring with a top-row pointer,
// so a scroll only zeroes the new bottom row. Clear zeroes the whole
// store one cell per cycle. The single write port of the cell RAM is
// shared by cell writes and sweeps. A new request is accepted while the
// previous result still waits in the output register.
`include "text_console_writer_top_defines.svh"

module text_console_writer_top #(
  parameter int SCREEN_COLS   = 80,
  parameter int SCREEN_ROWS_N = 25
) (
  input logic          clk,
  input logic          rst,
  tcw_item_if.sink     item,
  tcw_result_if.source result
);

  localparam int LAST_ROW = SCREEN_ROWS_N - 1;

  tcw_pkg::tcw_cmd_t  cmd;
  tcw_pkg::tcw_stat_t stat;

  tcw_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  tcw_datapath #(
    .SCREEN_COLS   (SCREEN_COLS),
    .SCREEN_ROWS_N (SCREEN_ROWS_N)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .stat   (stat)
  );

  `TCW_ASSERT_NEXT(a_one_in_flight, item.valid && item.ready, !item.ready, "second request accepted while busy")
  `TCW_ASSERT_IMPL(a_row_bound, result.valid, result.cursor_row <= LAST_ROW[tcw_pkg::ROW_W-1:0], "cursor row past bottom")
  `TCW_ASSERT_IMPL(a_drop_no_data, result.valid && result.dropped, result.cell_char == '0 && result.cell_attr == '0, "dropped request returned cell data")
  `TCW_ASSERT_IMPL(a_scroll_home, result.valid && result.scrolled, result.cursor_col == '0 && result.cursor_row == LAST_ROW[tcw_pkg::ROW_W-1:0], "scroll left cursor off bottom line start")

endmodule
